// ----- design/cisp_pkg.sv -----
// Shared constants and register codes for the clamped inverse-square pair force block.
`timescale 1ns / 1ps
`default_nettype none
package cisp_pkg;

  // Field widths
  localparam int POS_W   = 24;
  localparam int MAG_W   = 16;
  localparam int FORCE_W = 24;
  localparam int MAXF_W  = 23;
  localparam int DMIN_W  = 32;

  // Register reset values
  localparam logic [MAG_W-1:0]  OWN_MAG_RESET  = 16'd0;
  localparam logic [MAXF_W-1:0] MAX_FORCE_RESET = 23'd2621440;
  localparam logic [DMIN_W-1:0] MIN_DSQ_RESET  = 32'd65536;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_OWN_MAG   = 2'd0,
    REG_MAX_FORCE = 2'd1,
    REG_MIN_DSQ   = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- design/clamped_inverse_square_pair_force.sv -----
// Clamped inverse-square pair force: top level with configuration and pipeline.
// Takes one contact pair per cycle while the output is not stalled and returns one
// force word per pair, in order. The pipeline is a chain of bit-per-stage units:
// a 29-stage square root of the floored squared distance, a 23-stage divider for the
// magnitude and two parallel 23-stage dividers for the components, plus six plain
// stages. The whole pipeline advances together whenever the output register is empty
// or its word is taken, so s_tready follows m_tready in the same cycle.
// Configuration writes are taken in every cycle and must only happen while idle.
`timescale 1ns / 1ps
`default_nettype none
module clamped_inverse_square_pair_force (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // self_x[23:0], self_y[47:24], other_x[71:48], other_y[95:72], other_magnetism[111:96]
  input  wire logic [111:0] s_tdata,
  // touching[0], first_is_sensor[1], second_is_sensor[2], other_is_magnet[3]
  input  wire logic [3:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // force_x[23:0], force_y[47:24]
  output logic [47:0]       m_tdata,
  // apply[0]
  output logic [0:0]        m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import cisp_pkg::*;

  localparam int AW  = POS_W + 1;       // |dx|
  localparam int PRW = 2 * MAG_W - 1;   // |product|
  localparam int DW  = 42;              // floored distance squared
  localparam int RW  = 29;              // root of distance squared << 16
  localparam int MW  = MAXF_W;
  localparam int SPW = 6 + PRW + 2 * AW + DW;
  localparam int MPW = 6 + 2 * AW + RW;

  logic [MAG_W-1:0]  own_mag;
  logic [MAXF_W-1:0] max_force;
  logic [DMIN_W-1:0] min_dsq;
  logic              en;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mag   <= OWN_MAG_RESET;
      max_force <= MAX_FORCE_RESET;
      min_dsq   <= MIN_DSQ_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_MAG:   own_mag   <= cfg_data[MAG_W-1:0];
        REG_MAX_FORCE: max_force <= cfg_data[MAXF_W-1:0];
        REG_MIN_DSQ:   min_dsq   <= cfg_data[DMIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline when the output register can move
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage A: differences, magnitudes and the magnetism product
  logic signed [AW-1:0]      dx, dy;
  logic signed [2*MAG_W-1:0] prod;
  logic                      a_vld, a_gate, a_nx, a_px, a_ny, a_py, a_pneg;
  logic [AW-1:0]             a_ax, a_ay;
  logic [PRW-1:0]            a_p;

  assign dx   = $signed({s_tdata[23], s_tdata[23:0]}) - $signed({s_tdata[71], s_tdata[71:48]});
  assign dy   = $signed({s_tdata[47], s_tdata[47:24]}) - $signed({s_tdata[95], s_tdata[95:72]});
  assign prod = $signed(own_mag) * $signed(s_tdata[111:96]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_gate <= s_tuser[0] && (s_tuser[1] || s_tuser[2]) && s_tuser[3];
      a_ax   <= dx[AW-1] ? AW'(-dx) : AW'(dx);
      a_ay   <= dy[AW-1] ? AW'(-dy) : AW'(dy);
      a_nx   <= dx[AW-1];
      a_px   <= !dx[AW-1] && (dx != '0);
      a_ny   <= dy[AW-1];
      a_py   <= !dy[AW-1] && (dy != '0);
      a_pneg <= prod[2*MAG_W-1];
      a_p    <= prod[2*MAG_W-1] ? PRW'(-prod) : PRW'(prod);
    end
  end

  // Stage B: squares
  logic                b_vld, b_gate, b_nx, b_px, b_ny, b_py, b_pneg;
  logic [AW-1:0]       b_ax, b_ay;
  logic [PRW-1:0]      b_p;
  logic [2*AW-1:0]     b_sqx, b_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sqx  <= a_ax * a_ax;
      b_sqy  <= a_ay * a_ay;
      b_gate <= a_gate;
      b_ax   <= a_ax;
      b_ay   <= a_ay;
      b_nx   <= a_nx;
      b_px   <= a_px;
      b_ny   <= a_ny;
      b_py   <= a_py;
      b_pneg <= a_pneg;
      b_p    <= a_p;
    end
  end

  // Stage C: sum, scale to Q16.16 and floor
  logic [2*AW:0]     sum_sq;
  logic [DW-1:0]     dsq, dfloor;
  logic              c_vld;
  logic [SPW-DW-1:0] c_pay;
  logic [DW-1:0]     c_d;

  assign sum_sq = (2*AW+1)'(b_sqx) + (2*AW+1)'(b_sqy);
  assign dsq    = DW'(sum_sq >> 8);
  assign dfloor = (min_dsq == '0) ? DW'(1) : DW'(min_dsq);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_d   <= (dsq < dfloor) ? dfloor : dsq;
      c_pay <= {b_gate, b_nx, b_px, b_ny, b_py, b_pneg, b_p, b_ax, b_ay};
    end
  end

  // Root of the floored distance squared, Q13.16
  logic           r_vld;
  logic [RW-1:0]  r_root;
  logic [SPW-1:0] r_pay;

  cisp_isqrt #(.VW(DW + 16), .PW(SPW)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (c_vld),
    .val     ({c_d, 16'b0}),
    .in_pay  ({c_pay, c_d}),
    .out_vld (r_vld),
    .root    (r_root),
    .out_pay (r_pay)
  );

  // Magnitude: |product| << 16 over the floored distance squared
  logic [PRW-1:0] r_p;
  logic [DW-1:0]  r_d;
  logic           q_vld;
  logic [MW-1:0]  q_m;
  logic [MPW-1:0] q_pay;

  assign r_p = r_pay[DW + 2*AW +: PRW];
  assign r_d = r_pay[DW-1:0];

  cisp_div #(.NW(PRW + 16), .DW(DW), .QB(MW), .PW(MPW)) u_div_mag (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (r_vld),
    .num     ({r_p, 16'b0}),
    .den     (r_d),
    .in_pay  ({r_pay[SPW-1:SPW-6], r_pay[DW +: 2*AW], r_root}),
    .out_vld (q_vld),
    .quo     (q_m),
    .out_pay (q_pay)
  );

  // Stage E: clamp the magnitude
  logic           e_vld;
  logic [MW-1:0]  e_m;
  logic [MPW-1:0] e_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_m   <= (q_m > max_force) ? max_force : q_m;
      e_pay <= q_pay;
    end
  end

  // Stage F: scale each component by the magnitude
  logic              f_vld;
  logic [AW+MW-1:0]  f_px, f_py;
  logic [RW-1:0]     f_root;
  logic [5:0]        f_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_px    <= e_pay[RW + AW +: AW] * e_m;
      f_py    <= e_pay[RW +: AW] * e_m;
      f_root  <= e_pay[RW-1:0];
      f_flags <= e_pay[MPW-1 -: 6];
    end
  end

  // Components: (|d| * M * 16) / root, saturated
  logic          x_vld, y_vld;
  logic [MW-1:0] x_q, y_q;
  logic [3:0]    x_pay;
  logic [1:0]    y_pay;

  cisp_div #(.NW(AW + MW + 4), .DW(RW), .QB(MW), .PW(4)) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .num     ({f_px, 4'b0}),
    .den     (f_root),
    .in_pay  ({f_flags[5], f_flags[0], f_flags[4], f_flags[3]}),
    .out_vld (x_vld),
    .quo     (x_q),
    .out_pay (x_pay)
  );

  cisp_div #(.NW(AW + MW + 4), .DW(RW), .QB(MW), .PW(2)) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .num     ({f_py, 4'b0}),
    .den     (f_root),
    .in_pay  (f_flags[2:1]),
    .out_vld (y_vld),
    .quo     (y_q),
    .out_pay (y_pay)
  );

  // Output register: apply the sign and zero the force of skipped pairs
  logic               neg_x, neg_y;
  logic [FORCE_W-1:0] fx, fy;

  assign neg_x = x_pay[2] ? x_pay[1] : x_pay[0];
  assign neg_y = x_pay[2] ? y_pay[1] : y_pay[0];
  assign fx    = neg_x ? FORCE_W'(-{1'b0, x_q}) : FORCE_W'({1'b0, x_q});
  assign fy    = neg_y ? FORCE_W'(-{1'b0, y_q}) : FORCE_W'({1'b0, y_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= x_vld && y_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser[0] <= x_pay[3];
      m_tdata    <= x_pay[3] ? {fy, fx} : '0;
    end
  end

`ifndef ASSERT_OFF
  // A held output word must hold back the input side
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output stalled");

  // A skipped pair carries zero force
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("skipped pair with non-zero force");

  // Both component dividers stay in step
  assert property (@(posedge clk) disable iff (rst)
    x_vld == y_vld)
    else $error("component dividers out of step");

  // Nothing is presented right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

// ----- design/cisp_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cisp_isqrt #(
  parameter int VW = 58,
  parameter int PW = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_vld,
  input  wire logic [VW-1:0]           val,
  input  wire logic [PW-1:0]           in_pay,
  output logic                         out_vld,
  output logic [(VW+1)/2-1:0]          root,
  output logic [PW-1:0]                out_pay
);
  localparam int RW = (VW + 1) / 2;
  localparam int TW = 2 * RW + 2;

  logic [TW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [PW-1:0] pay_q  [RW];
  logic          vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int I = RW - 1 - k;
    logic [TW-1:0] rem_in;
    logic [TW-1:0] trial;
    logic [RW-1:0] root_in;
    logic [PW-1:0] pay_in;
    logic          vld_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = TW'(val);
      assign root_in = '0;
      assign pay_in  = in_pay;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign pay_in  = pay_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 2^(2i)
    assign trial = (TW'(root_in) << (I + 1)) + (TW'(1) << (2 * I));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? rem_in - trial : rem_in;
        root_q[k] <= take ? (root_in | (RW'(1) << I)) : root_in;
        pay_q[k]  <= pay_in;
      end
    end
  end

  assign out_vld = vld_q[RW-1];
  assign root    = root_q[RW-1];
  assign out_pay = pay_q[RW-1];

endmodule
`default_nettype wire

// ----- design/cisp_div.sv -----
// Pipelined restoring divider with a saturating quotient, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cisp_div #(
  parameter int NW = 47,
  parameter int DW = 42,
  parameter int QB = 23,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_vld,
  output logic [QB-1:0]      quo,
  output logic [PW-1:0]      out_pay
);
  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [CW-1:0] rem_q [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic          ovf_q [QB];
  logic [PW-1:0] pay_q [QB];
  logic          vld_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int I = QB - 1 - k;
    logic [CW-1:0] rem_in;
    logic [CW-1:0] sub;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [PW-1:0] pay_in;
    logic          ovf_in;
    logic          vld_in;
    logic          take;

    if (k == 0) begin : g_first
      // Quotient too wide for QB bits: saturate at the end
      assign ovf_in = CW'(num) >= (CW'(den) << QB);
      assign rem_in = CW'(num);
      assign den_in = den;
      assign quo_in = '0;
      assign pay_in = in_pay;
      assign vld_in = in_vld;
    end else begin : g_next
      assign ovf_in = ovf_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign pay_in = pay_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign sub  = CW'(den_in) << I;
    assign take = rem_in >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= take ? rem_in - sub : rem_in;
        quo_q[k] <= take ? (quo_in | (QB'(1) << I)) : quo_in;
        den_q[k] <= den_in;
        ovf_q[k] <= ovf_in;
        pay_q[k] <= pay_in;
      end
    end
  end

  assign out_vld = vld_q[QB-1];
  assign quo     = ovf_q[QB-1] ? '1 : quo_q[QB-1];
  assign out_pay = pay_q[QB-1];

endmodule
`default_nettype wire
